// ----- rtl/core/usvc_pkg.sv -----
// ----------------------------------------------------------------------------
// usvc_pkg
// Shared types and constants of the UTF-8 stream validator and counter.
// ----------------------------------------------------------------------------
package usvc_pkg;

    // Largest string length in bytes; a real byte beyond it is an error.
    localparam logic [31:0] MAX_BYTES = 32'd65535;

    // Effective limit on the 16-bit byte counter: MAX_BYTES, capped at the
    // counter's own ceiling.
    localparam logic [15:0] BYTE_LIMIT =
        (MAX_BYTES < 32'h0000_FFFF) ? 16'(MAX_BYTES) : 16'hFFFF;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_INVALID   = 2'd1;
    localparam status_t STATUS_TRUNCATED = 2'd2;
    localparam status_t STATUS_TOO_LONG  = 2'd3;

    // Kind of lead byte whose second byte carries an extra range check
    typedef logic [2:0] lead_kind_t;

    localparam lead_kind_t LEAD_PLAIN = 3'd0;
    localparam lead_kind_t LEAD_E0    = 3'd1;
    localparam lead_kind_t LEAD_ED    = 3'd2;
    localparam lead_kind_t LEAD_F0    = 3'd3;
    localparam lead_kind_t LEAD_F4    = 3'd4;

    // Per-string decoder state
    typedef struct packed {
        logic [1:0]  bytes_left;
        lead_kind_t  lead_kind;
        logic        at_second_byte;
        logic [15:0] chars_seen;
        logic [15:0] bytes_seen;
        logic [15:0] prefix_length;
        status_t     error_code;
    } str_state_t;

endpackage

// ----- rtl/core/usvc_if.sv -----
// ----------------------------------------------------------------------------
// usvc_if
// Valid/ready channels of the UTF-8 validator: byte stream and result.
// ----------------------------------------------------------------------------
interface usvc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last,
                    output ready);
endinterface

interface usvc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] char_count;
    logic [15:0] prefix_bytes;
    logic        prefix_reached;

    modport source (output valid, output status, output char_count,
                    output prefix_bytes, output prefix_reached, input ready);
    modport sink   (input valid, input status, input char_count,
                    input prefix_bytes, input prefix_reached, output ready);
endinterface

// ----- rtl/core/usvc_step.sv -----
// ----------------------------------------------------------------------------
// usvc_step
// One byte of strict UTF-8 decoding: next string state from current state.
// ----------------------------------------------------------------------------
module usvc_step
    import usvc_pkg::*;
#(
    parameter logic [31:0] MAX_BYTES = usvc_pkg::MAX_BYTES
)
(
    input  str_state_t  cur,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic [15:0] prefix_chars,
    output str_state_t  nxt
);

    // MAX_BYTES, capped at the ceiling of the 16-bit byte counter
    localparam logic [15:0] BYTE_CAP =
        (MAX_BYTES < 32'h0000_FFFF) ? MAX_BYTES[15:0] : 16'hFFFF;

    logic [15:0] bytes_inc;
    logic [15:0] chars_inc;
    logic        second_bad;

    assign bytes_inc = cur.bytes_seen + 16'd1;
    assign chars_inc = cur.chars_seen + 16'd1;

    always_comb
    begin
        case (cur.lead_kind)
            LEAD_E0: second_bad = (data_byte < 8'hA0);
            LEAD_ED: second_bad = (data_byte > 8'h9F);
            LEAD_F0: second_bad = (data_byte < 8'h90);
            LEAD_F4: second_bad = (data_byte > 8'h8F);
            default: second_bad = 1'b0;
        endcase
    end

    always_comb
    begin
        nxt = cur;
        if (has_byte && cur.error_code == STATUS_OK)
        begin
            if (cur.bytes_seen >= BYTE_CAP)
            begin
                nxt.error_code = STATUS_TOO_LONG;
            end
            else
            begin
                nxt.bytes_seen = bytes_inc;
                if (cur.bytes_left == 2'd0)
                begin
                    if (data_byte < 8'h80)
                    begin
                        nxt.chars_seen = chars_inc;
                        if (chars_inc == prefix_chars)
                            nxt.prefix_length = bytes_inc;
                    end
                    else if (data_byte >= 8'hC2 && data_byte <= 8'hDF)
                    begin
                        nxt.bytes_left     = 2'd1;
                        nxt.lead_kind      = LEAD_PLAIN;
                        nxt.at_second_byte = 1'b1;
                    end
                    else if (data_byte >= 8'hE0 && data_byte <= 8'hEF)
                    begin
                        nxt.bytes_left     = 2'd2;
                        nxt.lead_kind      = (data_byte == 8'hE0) ? LEAD_E0 :
                                             (data_byte == 8'hED) ? LEAD_ED : LEAD_PLAIN;
                        nxt.at_second_byte = 1'b1;
                    end
                    else if (data_byte >= 8'hF0 && data_byte <= 8'hF4)
                    begin
                        nxt.bytes_left     = 2'd3;
                        nxt.lead_kind      = (data_byte == 8'hF0) ? LEAD_F0 :
                                             (data_byte == 8'hF4) ? LEAD_F4 : LEAD_PLAIN;
                        nxt.at_second_byte = 1'b1;
                    end
                    else
                    begin
                        nxt.error_code = STATUS_INVALID;
                    end
                end
                else if (data_byte[7:6] != 2'b10)
                begin
                    nxt.error_code = STATUS_INVALID;
                end
                else if (cur.at_second_byte && second_bad)
                begin
                    nxt.error_code = STATUS_INVALID;
                end
                else
                begin
                    nxt.at_second_byte = 1'b0;
                    nxt.bytes_left     = cur.bytes_left - 2'd1;
                    if (cur.bytes_left == 2'd1)
                    begin
                        // final continuation byte closes the character
                        nxt.lead_kind  = LEAD_PLAIN;
                        nxt.chars_seen = chars_inc;
                        if (chars_inc == prefix_chars)
                            nxt.prefix_length = bytes_inc;
                    end
                end
            end
        end
    end

endmodule

// ----- rtl/core/utf8_stream_validate_count.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_validate_count
// Strict UTF-8 validator with character count and prefix byte length.
// ----------------------------------------------------------------------------
// Usage:
//   byte_stream carries one byte of a string per transaction (data_byte,
//   has_byte, last). has_byte = 0 marks a transaction with no real byte;
//   last = 1 closes the string. Each string yields exactly one transaction
//   on result: status, char_count, prefix_bytes, prefix_reached.
//   prefix_chars_we / prefix_chars_wdata write the prefix length register;
//   write it only while no string is in flight.
// Timing:
//   One byte per cycle sustained; a new transaction is taken every cycle
//   unless a closing transaction is held in the input register. The result
//   is registered: the closing byte passes the input register, then the
//   decode step and close-out logic feed the result register.
// Reset:
//   rst_n clears all string state, the prefix register and both valid
//   flags; byte_stream.ready is high as soon as reset is released.
// Stall:
//   While result waits for ready, non-final bytes keep flowing; a closing
//   transaction holds in the input register until the result slot frees.
// ----------------------------------------------------------------------------
module utf8_stream_validate_count
    import usvc_pkg::*;
#(
    // Longest string in bytes; a real byte beyond it ends in status too long
    parameter logic [31:0] MAX_BYTES = usvc_pkg::MAX_BYTES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    usvc_byte_if.sink            byte_stream,
    usvc_result_if.source        result,
    input  logic                 prefix_chars_we,
    input  logic [15:0]          prefix_chars_wdata
);

    // Configuration
    logic [15:0] prefix_chars_reg;

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_has_reg;
    logic        in_last_reg;

    // String state
    str_state_t  state_reg;
    str_state_t  state_next;

    // Result register
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [15:0] out_count_reg;
    logic [15:0] out_prefix_reg;
    logic        out_reached_reg;

    logic        advance;
    logic        out_free;
    status_t     final_status;
    logic        reached;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prefix_chars_reg <= '0;
        else if (prefix_chars_we)
            prefix_chars_reg <= prefix_chars_wdata;
    end

    // Result slot frees when empty or being taken this cycle
    assign out_free = !out_valid_reg || result.ready;

    // Advance the held byte: non-final bytes always, the closing one only
    // when the result register can take it
    assign advance = in_valid_reg && (!in_last_reg || out_free);

    assign byte_stream.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (byte_stream.ready)
            in_valid_reg <= byte_stream.valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.ready && byte_stream.valid)
        begin
            in_byte_reg <= byte_stream.data_byte;
            in_has_reg  <= byte_stream.has_byte;
            in_last_reg <= byte_stream.last;
        end
    end

    usvc_step #(
        .MAX_BYTES (MAX_BYTES)
    ) u_step (
        .cur          (state_reg),
        .data_byte    (in_byte_reg),
        .has_byte     (in_has_reg),
        .prefix_chars (prefix_chars_reg),
        .nxt          (state_next)
    );

    // Close out the string: a clean stream that still expects
    // continuation bytes is truncated
    always_comb
    begin
        final_status = state_next.error_code;
        if (final_status == STATUS_OK && state_next.bytes_left != 2'd0)
            final_status = STATUS_TRUNCATED;
    end

    assign reached = (state_next.chars_seen >= prefix_chars_reg);

    // Drop string state back to reset once the closing byte is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
        begin
            if (in_last_reg)
                state_reg <= '0;
            else
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // Error results report zero for all counts
    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_status_reg <= final_status;
            if (final_status == STATUS_OK)
            begin
                out_count_reg   <= state_next.chars_seen;
                out_prefix_reg  <= reached ? state_next.prefix_length : 16'd0;
                out_reached_reg <= reached;
            end
            else
            begin
                out_count_reg   <= 16'd0;
                out_prefix_reg  <= 16'd0;
                out_reached_reg <= 1'b0;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = out_status_reg;
    assign result.char_count     = out_count_reg;
    assign result.prefix_bytes   = out_prefix_reg;
    assign result.prefix_reached = out_reached_reg;

endmodule
